// ===== rtl/ddprr_pkg.sv =====
package ddprr_pkg;

    // Field widths
    localparam int unsigned DW  = 32;   // stress and register width, Q15.16
    localparam int unsigned YW  = 48;   // yield value width, Q31.16
    localparam int unsigned IW  = 34;   // first invariant width
    localparam int unsigned MW  = 35;   // multiplier operand width
    localparam int unsigned PW  = 2 * MW;
    localparam int unsigned QW  = PW - 16;  // product after the Q.16 shift
    localparam int unsigned FW  = QW + 2;   // yield and normal line width
    localparam int unsigned RW  = 32;   // square root width
    localparam int unsigned XW  = 64;   // square root radicand width

    // Division by three: floor(n / 3) = (n * DIV3_MUL) >> DIV3_SHIFT for n < 2^28
    localparam int unsigned DIV3_SHIFT = 29;
    localparam logic [27:0] DIV3_MUL   = 28'd178956971;

    localparam logic signed [FW-1:0] YIELD_MAX = FW'(64'sd140737488355327);
    localparam logic signed [FW-1:0] YIELD_MIN = FW'(-64'sd140737488355328);

    typedef enum logic [2:0] {
        REGION_ELASTIC     = 3'd0,
        REGION_TENSILE     = 3'd1,
        REGION_COMPRESSIVE = 3'd2,
        REGION_CORNER      = 3'd3,
        REGION_APEX        = 3'd4
    } region_t;

    typedef enum logic [2:0] {
        CFG_TENSILE_SLOPE      = 3'd0,
        CFG_TENSILE_OFFSET     = 3'd1,
        CFG_COMPRESSIVE_SLOPE  = 3'd2,
        CFG_COMPRESSIVE_OFFSET = 3'd3,
        CFG_CORNER_I           = 3'd4,
        CFG_CORNER_J           = 3'd5,
        CFG_APEX_I             = 3'd6
    } cfg_index_t;

endpackage

// ===== rtl/double_drucker_prager_return_region_core.sv =====
// Return-region selector for a double Drucker-Prager yield surface.
//
// Input channel: item_valid / item_stall carry one stress state (three normal,
// three shear components, signed Q15.16). An item is taken at a rising edge
// with item_valid high and item_stall low.
// Output channel: result_valid / result_stall carry the return region and the
// yield value (signed Q31.16, saturated to 48 bits) of one item.
// Configuration: write cfg_data to register cfg_index while cfg_we is high;
// index 7 is ignored. Write only while no item is in flight.
//
// Pipeline: five stages form I1 and J2 (differences, squares, sums, and a
// two-step division by six), 32 stages resolve sqrt(J2) one root bit each,
// three stages evaluate the cone and normal lines, and the output register
// selects the region and saturates.
// Throughput: one item per cycle while the pipeline is not stalled; every stage holds one item.
// Stall: while the output register holds an untaken result and result_stall
// is high, the whole pipeline holds and item_stall is raised.
// Reset: all valid bits clear and the configuration registers read zero.
module double_drucker_prager_return_region_core
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,

    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic signed [31:0]   stress_xx,
    input  logic signed [31:0]   stress_yy,
    input  logic signed [31:0]   stress_zz,
    input  logic signed [31:0]   shear_yz,
    input  logic signed [31:0]   shear_zx,
    input  logic signed [31:0]   shear_xy,

    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [2:0]           return_region,
    output logic signed [47:0]   yield_value
);

    localparam int unsigned DW = ddprr_pkg::DW;
    localparam int unsigned IW = ddprr_pkg::IW;
    localparam int unsigned MW = ddprr_pkg::MW;
    localparam int unsigned PW = ddprr_pkg::PW;
    localparam int unsigned QW = ddprr_pkg::QW;
    localparam int unsigned FW = ddprr_pkg::FW;
    localparam int unsigned RW = ddprr_pkg::RW;
    localparam int unsigned XW = ddprr_pkg::XW;
    localparam int unsigned YW = ddprr_pkg::YW;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [DW-1:0] tslope_reg, toffs_reg, cslope_reg, coffs_reg;
    logic signed [DW-1:0] corner_i_reg, corner_j_reg, apex_i_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tslope_reg   <= '0;
            toffs_reg    <= '0;
            cslope_reg   <= '0;
            coffs_reg    <= '0;
            corner_i_reg <= '0;
            corner_j_reg <= '0;
            apex_i_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (ddprr_pkg::cfg_index_t'(cfg_index))
                ddprr_pkg::CFG_TENSILE_SLOPE:      tslope_reg   <= cfg_data;
                ddprr_pkg::CFG_TENSILE_OFFSET:     toffs_reg    <= cfg_data;
                ddprr_pkg::CFG_COMPRESSIVE_SLOPE:  cslope_reg   <= cfg_data;
                ddprr_pkg::CFG_COMPRESSIVE_OFFSET: coffs_reg    <= cfg_data;
                ddprr_pkg::CFG_CORNER_I:           corner_i_reg <= cfg_data;
                ddprr_pkg::CFG_CORNER_J:           corner_j_reg <= cfg_data;
                ddprr_pkg::CFG_APEX_I:             apex_i_reg   <= cfg_data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: every stage moves together unless a finished
    // result waits in the output register and the receiver stalls.
    // ------------------------------------------------------------------
    logic adv;
    logic out_valid_reg;

    assign adv        = !out_valid_reg || !result_stall;
    assign item_stall = !adv;

    // ------------------------------------------------------------------
    // P1: normal differences and the first invariant
    // ------------------------------------------------------------------
    logic                 v1_reg;
    logic signed [32:0]   dxy_reg, dyz_reg, dzx_reg;
    logic signed [DW-1:0] syz_reg, szx_reg, sxy_reg;
    logic signed [IW-1:0] i1_p1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dxy_reg   <= 33'(stress_xx) - 33'(stress_yy);
            dyz_reg   <= 33'(stress_yy) - 33'(stress_zz);
            dzx_reg   <= 33'(stress_zz) - 33'(stress_xx);
            syz_reg   <= shear_yz;
            szx_reg   <= shear_zx;
            sxy_reg   <= shear_xy;
            i1_p1_reg <= IW'(stress_xx) + IW'(stress_yy) + IW'(stress_zz);
        end
    end

    // ------------------------------------------------------------------
    // P2: squares, floor(d*d / 2^16)
    // ------------------------------------------------------------------
    logic                 v2_reg;
    logic [47:0]          qxy_reg, qyz_reg, qzx_reg, qsyz_reg, qszx_reg, qsxy_reg;
    logic signed [IW-1:0] i1_p2_reg;
    logic signed [65:0]   pxy, pyz, pzx;
    logic signed [63:0]   psyz, pszx, psxy;

    assign pxy  = 66'(dxy_reg) * 66'(dxy_reg);
    assign pyz  = 66'(dyz_reg) * 66'(dyz_reg);
    assign pzx  = 66'(dzx_reg) * 66'(dzx_reg);
    assign psyz = 64'(syz_reg) * 64'(syz_reg);
    assign pszx = 64'(szx_reg) * 64'(szx_reg);
    assign psxy = 64'(sxy_reg) * 64'(sxy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qxy_reg   <= pxy[63:16];
            qyz_reg   <= pyz[63:16];
            qzx_reg   <= pzx[63:16];
            qsyz_reg  <= psyz[63:16];
            qszx_reg  <= pszx[63:16];
            qsxy_reg  <= psxy[63:16];
            i1_p2_reg <= i1_p1_reg;
        end
    end

    // ------------------------------------------------------------------
    // P3: sums; halve the normal sum (x/6 = (x/2)/3)
    // ------------------------------------------------------------------
    logic                 v3_reg;
    logic [48:0]          half_reg;
    logic [48:0]          shsum_reg;
    logic signed [IW-1:0] i1_p3_reg;
    logic [49:0]          nsum;

    assign nsum = 50'(qxy_reg) + 50'(qyz_reg) + 50'(qzx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            half_reg  <= nsum[49:1];
            shsum_reg <= 49'(qsyz_reg) + 49'(qszx_reg) + 49'(qsxy_reg);
            i1_p3_reg <= i1_p2_reg;
        end
    end

    // ------------------------------------------------------------------
    // P4: divide the upper 23 bits by three, fold the remainder down
    // ------------------------------------------------------------------
    logic                 v4_reg;
    logic [21:0]          qhi_reg;
    logic [27:0]          tlo_reg;
    logic [48:0]          shsum_p4_reg;
    logic signed [IW-1:0] i1_p4_reg;
    logic [22:0]          hi_part;
    logic [50:0]          phi;
    logic [21:0]          qhi;
    logic [22:0]          rhi;

    assign hi_part = half_reg[48:26];
    assign phi     = 51'(hi_part) * 51'(ddprr_pkg::DIV3_MUL);
    assign qhi     = phi[50:ddprr_pkg::DIV3_SHIFT];
    assign rhi     = hi_part - (23'(qhi) + {qhi, 1'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (adv)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qhi_reg      <= qhi;
            tlo_reg      <= {rhi[1:0], half_reg[25:0]};
            shsum_p4_reg <= shsum_reg;
            i1_p4_reg    <= i1_p3_reg;
        end
    end

    // ------------------------------------------------------------------
    // P5: finish the division, form J2 and the radicand J2 * 2^14
    // ------------------------------------------------------------------
    logic [55:0] plo;
    logic [26:0] qlo;
    logic [49:0] j2;

    assign plo = 56'(tlo_reg) * 56'(ddprr_pkg::DIV3_MUL);
    assign qlo = plo[55:ddprr_pkg::DIV3_SHIFT];
    assign j2  = {qhi_reg, 26'b0} + 50'(qlo) + 50'(shsum_p4_reg);

    // Square root stages: stage s resolves root bit RW-1-s.
    logic                 vq_reg    [0:RW];
    logic [XW-1:0]        rem_reg   [0:RW];
    logic [RW-1:0]        root_reg  [0:RW];
    logic signed [IW-1:0] i1_q_reg  [0:RW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vq_reg[0] <= 1'b0;
        else if (adv)
            vq_reg[0] <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= {j2, 14'b0};
            root_reg[0] <= '0;
            i1_q_reg[0] <= i1_p4_reg;
        end
    end

    for (genvar s = 0; s < RW; s++)
    begin : g_sqrt
        localparam int unsigned K = RW - 1 - s;

        logic [XW+1:0] trial;
        logic          take;

        // root bits lie above K, so OR places 2^(2K) without a carry
        assign trial = ((XW+2)'(root_reg[s]) << (K + 1)) | ((XW+2)'(1) << (2 * K));
        assign take  = (XW+2)'(rem_reg[s]) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vq_reg[s+1] <= 1'b0;
            else if (adv)
                vq_reg[s+1] <= vq_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s+1]  <= take ? rem_reg[s] - trial[XW-1:0] : rem_reg[s];
                root_reg[s+1] <= take ? root_reg[s] | (RW'(1) << K) : root_reg[s];
                i1_q_reg[s+1] <= i1_q_reg[s];
            end
        end
    end

    // ------------------------------------------------------------------
    // A: j = 2*root, offsets from the corner and the apex
    // ------------------------------------------------------------------
    logic                 va_reg;
    logic signed [MW-1:0] i1_a_reg, j_a_reg, di_reg, dj_reg, da_reg;
    logic signed [MW-1:0] j_sq;

    assign j_sq = MW'({root_reg[RW], 1'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (adv)
            va_reg <= vq_reg[RW];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            i1_a_reg <= MW'(i1_q_reg[RW]);
            j_a_reg  <= j_sq;
            di_reg   <= MW'(i1_q_reg[RW]) - MW'(corner_i_reg);
            dj_reg   <= j_sq - MW'(corner_j_reg);
            da_reg   <= MW'(i1_q_reg[RW]) - MW'(apex_i_reg);
        end
    end

    // ------------------------------------------------------------------
    // B: Q.16 products, floored toward minus infinity
    // ------------------------------------------------------------------
    logic                 vb_reg;
    logic signed [QW-1:0] mti_reg, mci_reg, mcd_reg, mtd_reg, mtj_reg;
    logic signed [QW-1:0] di2_reg, dj2_reg, da2_reg, jj_reg;
    logic signed [MW-1:0] i1_b_reg, j_b_reg, di_b_reg;
    logic signed [PW-1:0] pti, pci, pcd, ptd, ptj, pdi, pdj, pda, pjj;

    assign pti = PW'(tslope_reg) * PW'(i1_a_reg);
    assign pci = PW'(cslope_reg) * PW'(i1_a_reg);
    assign pcd = PW'(cslope_reg) * PW'(dj_reg);
    assign ptd = PW'(tslope_reg) * PW'(dj_reg);
    assign ptj = PW'(tslope_reg) * PW'(j_a_reg);
    assign pdi = PW'(di_reg) * PW'(di_reg);
    assign pdj = PW'(dj_reg) * PW'(dj_reg);
    assign pda = PW'(da_reg) * PW'(da_reg);
    assign pjj = PW'(j_a_reg) * PW'(j_a_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (adv)
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mti_reg  <= pti[PW-1:16];
            mci_reg  <= pci[PW-1:16];
            mcd_reg  <= pcd[PW-1:16];
            mtd_reg  <= ptd[PW-1:16];
            mtj_reg  <= ptj[PW-1:16];
            di2_reg  <= pdi[PW-1:16];
            dj2_reg  <= pdj[PW-1:16];
            da2_reg  <= pda[PW-1:16];
            jj_reg   <= pjj[PW-1:16];
            i1_b_reg <= i1_a_reg;
            j_b_reg  <= j_a_reg;
            di_b_reg <= di_reg;
        end
    end

    // ------------------------------------------------------------------
    // C: cone functions, normal lines, squared corner and apex distances
    // ------------------------------------------------------------------
    logic                 vc_reg;
    logic signed [FW-1:0] f1_reg, f2_reg, n1_reg, n2_reg, n3_reg, cv_reg, av_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else if (adv)
            vc_reg <= vb_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_reg <= FW'(mti_reg) + FW'(j_b_reg) - FW'(toffs_reg);
            f2_reg <= FW'(mci_reg) + FW'(j_b_reg) - FW'(coffs_reg);
            n1_reg <= FW'(mcd_reg) - FW'(di_b_reg);
            n2_reg <= FW'(mtd_reg) - FW'(di_b_reg);
            n3_reg <= FW'(mtj_reg) - FW'(i1_b_reg) + FW'(apex_i_reg);
            cv_reg <= FW'(di2_reg) + FW'(dj2_reg);
            av_reg <= FW'(da2_reg) + FW'(jj_reg);
        end
    end

    // ------------------------------------------------------------------
    // Output: pick the region and its value, saturate to 48 bits
    // ------------------------------------------------------------------
    ddprr_pkg::region_t   region_next;
    logic signed [FW-1:0] val_sel;
    logic signed [YW-1:0] val_next;
    logic                 f1_pos, f2_pos;

    assign f1_pos = f1_reg > 0;
    assign f2_pos = f2_reg > 0;

    always_comb
    begin
        if (!f1_pos && !f2_pos)
            region_next = ddprr_pkg::REGION_ELASTIC;
        else if (f1_pos && !f2_pos)
            region_next = (n3_reg < 0) ? ddprr_pkg::REGION_APEX : ddprr_pkg::REGION_TENSILE;
        else if (!f1_pos)
            region_next = ddprr_pkg::REGION_COMPRESSIVE;
        else if (n1_reg >= 0)
            region_next = ddprr_pkg::REGION_COMPRESSIVE;
        else if (n2_reg > 0)
            region_next = ddprr_pkg::REGION_CORNER;
        else if (n3_reg >= 0)
            region_next = ddprr_pkg::REGION_TENSILE;
        else
            region_next = ddprr_pkg::REGION_APEX;

        case (region_next)
            ddprr_pkg::REGION_ELASTIC,
            ddprr_pkg::REGION_TENSILE:     val_sel = f1_reg;
            ddprr_pkg::REGION_COMPRESSIVE: val_sel = f2_reg;
            ddprr_pkg::REGION_CORNER:      val_sel = cv_reg;
            default:                       val_sel = av_reg;
        endcase

        if (val_sel > ddprr_pkg::YIELD_MAX)
            val_next = YW'(ddprr_pkg::YIELD_MAX);
        else if (val_sel < ddprr_pkg::YIELD_MIN)
            val_next = YW'(ddprr_pkg::YIELD_MIN);
        else
            val_next = val_sel[YW-1:0];
    end

    ddprr_pkg::region_t   region_reg;
    logic signed [YW-1:0] value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= vc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            region_reg <= region_next;
            value_reg  <= val_next;
        end
    end

    assign result_valid  = out_valid_reg;
    assign return_region = region_reg;
    assign yield_value   = value_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("input stalled without output backpressure");

    a_region_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (return_region <= 3'(ddprr_pkg::REGION_APEX)))
        else $error("return region out of range");

    a_elastic_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && return_region == 3'(ddprr_pkg::REGION_ELASTIC))
            |-> (yield_value <= 0))
        else $error("elastic item with positive yield value");

    a_distance_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (return_region == 3'(ddprr_pkg::REGION_CORNER)
            || return_region == 3'(ddprr_pkg::REGION_APEX))) |-> (yield_value >= 0))
        else $error("negative corner or apex distance");

endmodule
